@@ hw/rtl/u2d_pkg.sv @@
// ----------------------------------------------------------------------------
// u2d_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2d_pkg;

  // Width of one BCD digit
  localparam int unsigned DIGIT_W = 4;

  // ASCII code of the character '0', at the output field width
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } u2d_state_t;

  // Per-cycle command broadcast to every digit cell
  typedef struct packed {
    logic clr;        // clear the digit
    logic bit_shift;  // add-3 adjust, then shift one binary bit in
    logic dig_shift;  // take the neighbor's digit (move toward the top)
  } u2d_cell_ctl_t;

endpackage : u2d_pkg

`default_nettype wire

@@ hw/rtl/uint_to_decimal_ascii.sv @@
// Order: after an input transfer the cells convert the number bit by bit, then
//   drain upward, skipping leading zeros before the first character is offered.
// Input: a new number is taken only once the last character of the previous one
//   has been loaded into the output register; out_stall can hold the drain.
// Reset: synchronous, active low; clears the controller and the output valid.
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii
// Unsigned binary to decimal ASCII text, most significant digit first, one
// character per transfer, leading zeros dropped, last character flagged.
// A chain of BCD cells converts one bit per cycle, then drains upward.
// ----------------------------------------------------------------------------
`default_nettype none

module uint_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [5:0]                 out_digit_char,
  output logic                       out_last_digit
);

  import u2d_pkg::*;

  // Decimal digits of the largest VALUE_BITS-bit value
  localparam int unsigned NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned CW   = $clog2(VALUE_BITS + 1);
  localparam int unsigned RW   = $clog2(NDIG + 1);

  u2d_state_t          state_r, state_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic                started_r, started_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [5:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  u2d_cell_ctl_t       ctl;

  logic [NDIG-1:0]     carry;
  logic [DIGIT_W-1:0]  dig [NDIG];
  logic [DIGIT_W-1:0]  top_dig;
  logic                out_free;

  assign top_dig  = dig[NDIG-1];
  assign out_free = !out_valid_r || !out_stall;

  // Chain of digit cells, least significant at index 0
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == 0) begin : g_low
      u2d_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (val_r[VALUE_BITS-1]),
        .bit_out (carry[i]),
        .dig_in  ('0),
        .dig_q   (dig[i])
      );
    end else begin : g_up
      u2d_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (carry[i-1]),
        .bit_out (carry[i]),
        .dig_in  (dig[i-1]),
        .dig_q   (dig[i])
      );
    end
  end

  // Next state, cell commands and output register load
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    in_stall      = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt     = in_value;
          cnt_nxt     = CW'(VALUE_BITS);
          started_nxt = 1'b0;
          ctl.clr     = 1'b1;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.bit_shift = 1'b1;
        val_nxt       = {val_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt       = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          rem_nxt   = RW'(NDIG);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Drop leading zeros, keep at least the final digit
        if (!started_r && (top_dig == '0) && (rem_r != RW'(1))) begin
          ctl.dig_shift = 1'b1;
          rem_nxt       = rem_r - RW'(1);
        end else if (out_free) begin
          ctl.dig_shift = 1'b1;
          rem_nxt       = rem_r - RW'(1);
          started_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {2'b00, top_dig};
          out_last_nxt  = (rem_r == RW'(1));
          if (rem_r == RW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  // Payload and counters
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule : uint_to_decimal_ascii

`default_nettype wire

@@ hw/rtl/u2d_cell.sv @@
// ----------------------------------------------------------------------------
// u2d_cell
// One BCD digit of the shift-add-3 chain. In bit mode it adjusts its digit
// and shifts in the carry from the cell below; in digit mode it takes the
// whole digit of the cell below, so the chain drains toward the top.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_cell (
  input  wire logic                          clk,
  input  wire u2d_pkg::u2d_cell_ctl_t        ctl,
  input  wire logic                          bit_in,
  output logic                               bit_out,
  input  wire logic [u2d_pkg::DIGIT_W-1:0]   dig_in,
  output logic [u2d_pkg::DIGIT_W-1:0]        dig_q
);

  import u2d_pkg::*;

  logic [DIGIT_W-1:0] dig_r;
  logic [DIGIT_W-1:0] adj;

  // Add 3 when the digit is five or more, so the next doubling carries out
  always_comb begin
    adj = (dig_r >= 4'd5) ? (dig_r + 4'd3) : dig_r;
  end

  assign bit_out = adj[DIGIT_W-1];
  assign dig_q   = dig_r;

  // Hold, clear, shift a bit in, or take the neighbor's digit
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      dig_r <= '0;
    end else if (ctl.bit_shift) begin
      dig_r <= {adj[DIGIT_W-2:0], bit_in};
    end else if (ctl.dig_shift) begin
      dig_r <= dig_in;
    end
  end

endmodule : u2d_cell

`default_nettype wire

@@ hw/rtl/u2d_checker.sv @@
// ----------------------------------------------------------------------------
// u2d_checker
// Port-level checks for the decimal ASCII converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [5:0] out_digit_char,
  input wire logic       out_last_digit
);

  // A stalled character stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit_char)
                               && $stable(out_last_digit))
    else $error("stalled result changed");

  // Only decimal digit characters come out
  a_out_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48) && (out_digit_char <= 6'd57))
    else $error("result is not a decimal digit");

  // An accepted number keeps the input busy on the next cycle
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while converting");

  // No new number is taken while a number's text is still unfinished
  a_busy_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_digit |-> in_stall)
    else $error("input ready before last character");

endmodule : u2d_checker

bind uint_to_decimal_ascii u2d_checker u_u2d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit)
);

`default_nettype wire

@@ tb/tb_uint_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uint_to_decimal_ascii
// Self-checking bench for the binary to decimal ASCII converter. Numbers are
// fed through a valid/stall channel with random gaps, the expected digit
// characters are computed for every accepted number, and each character
// transfer is checked in order against them, including the last-digit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_uint_to_decimal_ascii;
  import u2d_pkg::*;

  localparam int unsigned NUM_BITS     = 32;
  localparam int unsigned RANDOM_ITEMS = 91;
  localparam int unsigned QUIET_TAIL   = 20;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct {
    logic [NUM_BITS-1:0] value;
    bit                  hold;   // wait for all text to drain before sending
  } number_item_t;

  typedef struct {
    logic [5:0] code;
    logic       last;
  } digit_char_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [NUM_BITS-1:0] in_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [5:0]          out_digit_char;
  logic                out_last_digit;

  number_item_t number_queue[$];
  digit_char_t  text_queue[$];
  int unsigned  error_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  send_gap = 0;
  int unsigned  stall_left = 0;
  bit           in_taken = 1'b0;

  uint_to_decimal_ascii #(
    .VALUE_BITS(NUM_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Append the decimal text of one number, most significant digit first
  task automatic predict_text(input logic [NUM_BITS-1:0] value);
    logic [5:0]          digits[$];
    logic [NUM_BITS-1:0] rest;
    digit_char_t         ch;
    rest = value;
    do begin
      digits.push_front(ASCII_ZERO + 6'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    foreach (digits[i]) begin
      ch.code = digits[i];
      ch.last = (i == digits.size() - 1);
      text_queue.push_back(ch);
    end
  endtask

  task automatic add_number(input logic [NUM_BITS-1:0] value, input bit hold);
    number_item_t item;
    item.value = value;
    item.hold  = hold;
    number_queue.push_back(item);
  endtask

  // Sample both channels, predict, check, and watch for a hang
  always @(posedge clk) begin
    digit_char_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken)
      predict_text(in_value);
    if (rst_n && out_valid && !out_stall) begin
      if (text_queue.size() == 0) begin
        error_count++;
        $display("%0t: unexpected char: expected none, actual char=%0d last=%0b",
                 $time, out_digit_char, out_last_digit);
      end else begin
        want = text_queue.pop_front();
        if (out_digit_char !== want.code) begin
          error_count++;
          $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                   $time, want.code, out_digit_char);
        end
        if (out_last_digit !== want.last) begin
          error_count++;
          $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                   $time, want.last, out_last_digit);
        end
      end
    end
    if (in_taken || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Feed numbers; advance only after a transfer or while idle
  always @(negedge clk) begin
    bit           quiet;
    number_item_t next_item;
    quiet = (number_queue.size() < QUIET_TAIL);
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (number_queue.size() != 0 &&
                   !(number_queue[0].hold && text_queue.size() != 0)) begin
        next_item = number_queue.pop_front();
        in_valid <= 1'b1;
        in_value <= next_item.value;
        if (!quiet && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Random stall bursts on the result side
  always @(negedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (number_queue.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 9);
    out_stall <= (stall_left > 0);
  end

  initial begin
    logic [NUM_BITS-1:0] value;

    // Directed: extremes, digit count boundaries, zero
    add_number(32'd0, 1'b0);
    add_number(32'd1, 1'b0);
    add_number(32'd9, 1'b0);
    add_number(32'd10, 1'b0);
    add_number(32'd99, 1'b0);
    add_number(32'd100, 1'b0);
    add_number(32'd1000, 1'b0);
    add_number(32'd65535, 1'b0);
    add_number(32'd999999999, 1'b0);
    add_number(32'd1000000000, 1'b0);
    add_number(32'h7FFF_FFFF, 1'b0);
    add_number(32'h8000_0000, 1'b0);
    add_number(32'd4294967294, 1'b0);
    add_number(32'hFFFF_FFFF, 1'b0);
    add_number(32'd123456789, 1'b0);
    add_number(32'h5555_5555, 1'b0);
    add_number(32'hAAAA_AAAA, 1'b0);
    add_number(32'd0, 1'b1);
    add_number(32'd4000000000, 1'b0);

    // Random: spread over all digit counts, with a few drain pauses
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      value = $urandom() >> $urandom_range(0, NUM_BITS - 1);
      if ($urandom_range(0, 9) == 0)
        value = $urandom();
      add_number(value, (i % 37) == 36);
    end

    // Hold reset, then release it at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all sent, all text seen, then a margin for stray output
    wait (number_queue.size() == 0 && !in_valid);
    wait (text_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule : tb_uint_to_decimal_ascii

`default_nettype wire
